FILE: rtl/core/mcd_pkg.sv
`timescale 1ns / 1ps
package mcd_pkg;

  // Field and register widths
  localparam int SAMPLE_W    = 8;
  localparam int SIDE_W      = 13;
  localparam int CHAN_W      = 3;
  localparam int CFG_W       = 13;
  localparam int CFG_IDX_W   = 3;
  localparam int SUM_W       = 32;
  localparam int VERDICT_W   = 3;
  localparam int DIFF_W      = 31;
  localparam int IN_TDATA_W  = 8;
  localparam int OUT_TDATA_W = 40;

  // Defaults and constants of the scoring
  localparam int DEF_MAX_CHANNELS  = 4;
  localparam int MAX_SIDE          = 4096;
  localparam int SAMPLE_FULL_SCALE = 255;
  localparam int PERCENT           = 100;
  localparam int PCT_W             = 7;
  localparam int FRAC_BITS         = 24;

  // Datapath widths
  localparam int NUM_W   = SUM_W + PCT_W;       // sum * 100
  localparam int DVD_W   = NUM_W + FRAC_BITS;   // dividend, sum * 100 * 2^24
  localparam int DEN_W   = 34;                  // width * height * k * 255
  localparam int QUO_W   = 56;                  // quotient, divisor is at least 255
  localparam int TOT_W   = QUO_W + 2;           // sum of up to four differences
  localparam int MUL_A_W = 32;
  localparam int MUL_B_W = 13;
  localparam int MUL_P_W = MUL_A_W + MUL_B_W;

  // Register indexes
  localparam logic [CFG_IDX_W-1:0] REG_BASE_WIDTH    = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_BASE_HEIGHT   = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_CMP_WIDTH     = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_CMP_HEIGHT    = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_BASE_CHANNELS = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_CMP_CHANNELS  = 3'd5;

  // Verdict codes
  localparam logic [VERDICT_W-1:0] VERDICT_IDENTICAL   = 3'd0;
  localparam logic [VERDICT_W-1:0] VERDICT_VERY_LIKELY = 3'd1;
  localparam logic [VERDICT_W-1:0] VERDICT_PROBABLY    = 3'd2;
  localparam logic [VERDICT_W-1:0] VERDICT_MAYBE       = 3'd3;
  localparam logic [VERDICT_W-1:0] VERDICT_NOT_DUP     = 3'd4;

  // Grading limits: 0.01, 0.1 and 0.2 percent-units times 2^24, truncated
  localparam logic [DIFF_W-1:0] LIMIT_VERY_LIKELY = 31'd167772;
  localparam logic [DIFF_W-1:0] LIMIT_PROBABLY    = 31'd1677721;
  localparam logic [DIFF_W-1:0] LIMIT_MAYBE       = 31'd3355443;
  localparam logic [DIFF_W-1:0] DIFF_MAX          = 31'h7FFF_FFFF;

  // Accumulator control from the sequencer
  typedef struct packed {
    logic add;
    logic is_cmp;
    logic clear;
  } acc_ctrl_t;

  // Divider status
  typedef struct packed {
    logic busy;
    logic done;
  } div_stat_t;

  // Side length: zero counts as one, large values stop at MAX_SIDE
  function automatic logic [SIDE_W-1:0] clamp_side(input logic [SIDE_W-1:0] v);
    logic [SIDE_W-1:0] r;
    r = v;
    if (v == '0) begin
      r = SIDE_W'(1);
    end else if (v > SIDE_W'(MAX_SIDE)) begin
      r = SIDE_W'(MAX_SIDE);
    end
    return r;
  endfunction

  // Channel count: zero counts as one, large values stop at maxc
  function automatic logic [CHAN_W-1:0] clamp_chan(input logic [CHAN_W-1:0] v,
                                                   input logic [CHAN_W-1:0] maxc);
    logic [CHAN_W-1:0] r;
    r = v;
    if (v == '0) begin
      r = CHAN_W'(1);
    end else if (v > maxc) begin
      r = maxc;
    end
    return r;
  endfunction

endpackage

FILE: rtl/core/mcd_accum.sv
`timescale 1ns / 1ps
module mcd_accum #(
  parameter int MAX_CHANNELS = mcd_pkg::DEF_MAX_CHANNELS,
  localparam int POS_W = (MAX_CHANNELS > 1) ? $clog2(MAX_CHANNELS) : 1
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  mcd_pkg::acc_ctrl_t            ctrl,
  input  logic [mcd_pkg::SAMPLE_W-1:0]  sample,
  input  logic [mcd_pkg::CHAN_W-1:0]    base_chan,
  input  logic [mcd_pkg::CHAN_W-1:0]    cmp_chan,
  input  logic [POS_W-1:0]              rd_idx,
  output logic [mcd_pkg::SUM_W-1:0]     rd_base_sum,
  output logic [mcd_pkg::SUM_W-1:0]     rd_cmp_sum
);
  import mcd_pkg::*;

  localparam logic [CHAN_W-1:0] MAXC = CHAN_W'(MAX_CHANNELS);

  logic [SUM_W-1:0]  base_sums_r [MAX_CHANNELS];
  logic [SUM_W-1:0]  base_sums_nxt [MAX_CHANNELS];
  logic [SUM_W-1:0]  cmp_sums_r [MAX_CHANNELS];
  logic [SUM_W-1:0]  cmp_sums_nxt [MAX_CHANNELS];
  logic [POS_W-1:0]  base_pos_r, base_pos_nxt;
  logic [POS_W-1:0]  cmp_pos_r, cmp_pos_nxt;
  logic [CHAN_W-1:0] base_ch, cmp_ch;
  logic [POS_W-1:0]  base_p, cmp_p;
  logic              base_add, cmp_add;

  assign base_ch  = clamp_chan(base_chan, MAXC);
  assign cmp_ch   = clamp_chan(cmp_chan, MAXC);
  assign base_add = ctrl.add && !ctrl.is_cmp;
  assign cmp_add  = ctrl.add && ctrl.is_cmp;

  // Position restarts at channel 0 if it lies past a shrunken count
  assign base_p = (CHAN_W'(base_pos_r) >= base_ch) ? '0 : base_pos_r;
  assign cmp_p  = (CHAN_W'(cmp_pos_r) >= cmp_ch) ? '0 : cmp_pos_r;

  // Next position and per-lane sums
  always_comb begin
    base_pos_nxt = base_pos_r;
    cmp_pos_nxt  = cmp_pos_r;
    if (base_add) begin
      base_pos_nxt = (CHAN_W'(base_p) + CHAN_W'(1) >= base_ch) ? '0 : POS_W'(base_p + 1'b1);
    end
    if (cmp_add) begin
      cmp_pos_nxt = (CHAN_W'(cmp_p) + CHAN_W'(1) >= cmp_ch) ? '0 : POS_W'(cmp_p + 1'b1);
    end
    if (ctrl.clear) begin
      base_pos_nxt = '0;
      cmp_pos_nxt  = '0;
    end
    for (int e = 0; e < MAX_CHANNELS; e++) begin
      base_sums_nxt[e] = base_sums_r[e];
      cmp_sums_nxt[e]  = cmp_sums_r[e];
      if (base_add && (base_p == POS_W'(e))) begin
        base_sums_nxt[e] = base_sums_r[e] + SUM_W'(sample);
      end
      if (cmp_add && (cmp_p == POS_W'(e))) begin
        cmp_sums_nxt[e] = cmp_sums_r[e] + SUM_W'(sample);
      end
      if (ctrl.clear) begin
        base_sums_nxt[e] = '0;
        cmp_sums_nxt[e]  = '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      base_pos_r <= '0;
      cmp_pos_r  <= '0;
      for (int e = 0; e < MAX_CHANNELS; e++) begin
        base_sums_r[e] <= '0;
        cmp_sums_r[e]  <= '0;
      end
    end else begin
      base_pos_r <= base_pos_nxt;
      cmp_pos_r  <= cmp_pos_nxt;
      for (int e = 0; e < MAX_CHANNELS; e++) begin
        base_sums_r[e] <= base_sums_nxt[e];
        cmp_sums_r[e]  <= cmp_sums_nxt[e];
      end
    end
  end

  // Read port for the scoring sequencer
  assign rd_base_sum = base_sums_r[rd_idx];
  assign rd_cmp_sum  = cmp_sums_r[rd_idx];

endmodule

FILE: rtl/core/mcd_div.sv
`timescale 1ns / 1ps
module mcd_div (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       start,
  input  logic [mcd_pkg::DVD_W-1:0]  dividend,
  input  logic [mcd_pkg::DEN_W-1:0]  divisor,
  output mcd_pkg::div_stat_t         stat,
  output logic [mcd_pkg::QUO_W-1:0]  quotient
);
  import mcd_pkg::*;

  localparam int CNT_W = $clog2(DVD_W);

  logic             busy_r, busy_nxt;
  logic             done_r, done_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic [DEN_W-1:0] rem_r, rem_nxt;
  logic [DVD_W-1:0] quo_r, quo_nxt;
  logic [DEN_W:0]   trial;
  logic [DEN_W:0]   diff;
  logic             fits;

  // One restoring step: shift in the next dividend bit, subtract if it fits
  assign trial = {rem_r, quo_r[DVD_W-1]};
  assign diff  = trial - {1'b0, divisor};
  assign fits  = trial >= {1'b0, divisor};

  always_comb begin
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    cnt_nxt  = cnt_r;
    rem_nxt  = rem_r;
    quo_nxt  = quo_r;
    if (start) begin
      busy_nxt = 1'b1;
      cnt_nxt  = '0;
      rem_nxt  = '0;
      quo_nxt  = dividend;
    end else if (busy_r) begin
      rem_nxt = fits ? diff[DEN_W-1:0] : trial[DEN_W-1:0];
      quo_nxt = {quo_r[DVD_W-2:0], fits};
      cnt_nxt = CNT_W'(cnt_r + 1'b1);
      if (cnt_r == CNT_W'(DVD_W - 1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    rem_r <= rem_nxt;
    quo_r <= quo_nxt;
  end

  assign stat.busy = busy_r;
  assign stat.done = done_r;
  assign quotient  = quo_r[QUO_W-1:0];

endmodule

FILE: rtl/core/channel_mean_difference_classifier.sv
`timescale 1ns / 1ps
// Mean channel difference classifier.
// Input stream: one sample byte per transaction on in_tdata; in_tuser is 0 for
// the base image and 1 for the comparison image; in_tlast marks the final
// sample of the image pair. Samples are added into per-channel sums, so a run
// of samples streams at one per clock except while the block is scoring.
// On the transaction with in_tlast the block scores the pair and drops
// in_tready while it does so. Six multiplier steps build both denominators,
// then per compared channel (k, the smaller channel count) and per image one
// multiply and a bit-serial divide, all on one shared multiplier and divider.
// The result (verdict and difference) is held in an output register until
// out_tready; new samples are taken while it waits. If the previous result is
// still unread when the next one is ready, scoring holds until it is taken.
// Configuration uses cfg_we/cfg_index/cfg_wdata; the user must write it only
// while idle, unenforced by the block. Reset (rst_n low, synchronous) restores
// register defaults, clears all sums and positions and drops out_tvalid.
module channel_mean_difference_classifier #(
  parameter int MAX_CHANNELS = mcd_pkg::DEF_MAX_CHANNELS
) (
  input  logic                             clk,
  input  logic                             rst_n,
  // configuration write port
  input  logic                             cfg_we,
  input  logic [mcd_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [mcd_pkg::CFG_W-1:0]        cfg_wdata,
  // sample stream
  input  logic                             in_tvalid,
  output logic                             in_tready,
  input  logic [mcd_pkg::IN_TDATA_W-1:0]   in_tdata,   // [7:0] sample
  input  logic                             in_tuser,   // [0] from_comparison
  input  logic                             in_tlast,
  // result stream
  output logic                             out_tvalid,
  input  logic                             out_tready,
  output logic [mcd_pkg::OUT_TDATA_W-1:0]  out_tdata   // [2:0] verdict, [33:3] difference
);
  import mcd_pkg::*;

  localparam int POS_W = (MAX_CHANNELS > 1) ? $clog2(MAX_CHANNELS) : 1;
  localparam int PAD_W = OUT_TDATA_W - DIFF_W - VERDICT_W;
  localparam logic [CHAN_W-1:0] MAXC = CHAN_W'(MAX_CHANNELS);

  // Denominator build steps
  localparam logic [2:0] DS_AREA_BASE  = 3'd0;
  localparam logic [2:0] DS_AREA_CMP   = 3'd1;
  localparam logic [2:0] DS_CHAN_BASE  = 3'd2;
  localparam logic [2:0] DS_CHAN_CMP   = 3'd3;
  localparam logic [2:0] DS_SCALE_BASE = 3'd4;
  localparam logic [2:0] DS_SCALE_CMP  = 3'd5;

  typedef enum logic [5:0] {
    S_IDLE  = 6'b000001,
    S_DEN   = 6'b000010,
    S_NUM   = 6'b000100,
    S_DIV   = 6'b001000,
    S_SUM   = 6'b010000,
    S_GRADE = 6'b100000
  } state_t;

  state_t              state_r, state_nxt;
  logic [2:0]          step_r, step_nxt;
  logic [CHAN_W-1:0]   ch_idx_r, ch_idx_nxt;
  logic                side_r, side_nxt;
  logic [DEN_W-1:0]    den_b_r, den_b_nxt;
  logic [DEN_W-1:0]    den_c_r, den_c_nxt;
  logic [QUO_W-1:0]    vb_r, vb_nxt;
  logic [QUO_W-1:0]    diff_r, diff_nxt;
  logic [TOT_W-1:0]    total_r, total_nxt;
  logic                out_valid_r, out_valid_nxt;
  logic [VERDICT_W-1:0] verdict_r, verdict_nxt;
  logic [DIFF_W-1:0]   difference_r, difference_nxt;

  logic [SIDE_W-1:0]   base_width_r, base_height_r, cmp_width_r, cmp_height_r;
  logic [CHAN_W-1:0]   base_chan_r, cmp_chan_r;

  logic [CHAN_W-1:0]   kb, kc, k;
  logic [MUL_A_W-1:0]  mul_a;
  logic [MUL_B_W-1:0]  mul_b;
  logic [MUL_P_W-1:0]  mul_p;
  logic [SUM_W-1:0]    rd_base_sum, rd_cmp_sum;
  logic [QUO_W-1:0]    quotient;
  div_stat_t           div_stat;
  logic                div_start;
  logic [DVD_W-1:0]    div_dividend;
  logic [DEN_W-1:0]    div_divisor;
  acc_ctrl_t           acc_ctrl;
  logic [DIFF_W-1:0]   diff_sat;
  logic [VERDICT_W-1:0] grade;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      base_width_r  <= SIDE_W'(1);
      base_height_r <= SIDE_W'(1);
      cmp_width_r   <= SIDE_W'(1);
      cmp_height_r  <= SIDE_W'(1);
      base_chan_r   <= CHAN_W'(3);
      cmp_chan_r    <= CHAN_W'(3);
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_BASE_WIDTH:    base_width_r  <= cfg_wdata[SIDE_W-1:0];
        REG_BASE_HEIGHT:   base_height_r <= cfg_wdata[SIDE_W-1:0];
        REG_CMP_WIDTH:     cmp_width_r   <= cfg_wdata[SIDE_W-1:0];
        REG_CMP_HEIGHT:    cmp_height_r  <= cfg_wdata[SIDE_W-1:0];
        REG_BASE_CHANNELS: base_chan_r   <= cfg_wdata[CHAN_W-1:0];
        REG_CMP_CHANNELS:  cmp_chan_r    <= cfg_wdata[CHAN_W-1:0];
        default: ;
      endcase
    end
  end

  // Channels compared: the smaller of the two counts
  assign kb = clamp_chan(base_chan_r, MAXC);
  assign kc = clamp_chan(cmp_chan_r, MAXC);
  assign k  = (kb <= kc) ? kb : kc;

  assign in_tready = (state_r == S_IDLE);

  // Sample accumulation
  assign acc_ctrl.add    = in_tvalid && in_tready;
  assign acc_ctrl.is_cmp = in_tuser;
  assign acc_ctrl.clear  = (state_r == S_GRADE) && (!out_valid_r || out_tready);

  mcd_accum #(.MAX_CHANNELS(MAX_CHANNELS)) u_accum (
    .clk         (clk),
    .rst_n       (rst_n),
    .ctrl        (acc_ctrl),
    .sample      (in_tdata[SAMPLE_W-1:0]),
    .base_chan   (base_chan_r),
    .cmp_chan    (cmp_chan_r),
    .rd_idx      (ch_idx_r[POS_W-1:0]),
    .rd_base_sum (rd_base_sum),
    .rd_cmp_sum  (rd_cmp_sum)
  );

  // Shared multiplier operand select
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    if (state_r == S_DEN) begin
      unique case (step_r)
        DS_AREA_BASE: begin
          mul_a = MUL_A_W'(clamp_side(base_width_r));
          mul_b = MUL_B_W'(clamp_side(base_height_r));
        end
        DS_AREA_CMP: begin
          mul_a = MUL_A_W'(clamp_side(cmp_width_r));
          mul_b = MUL_B_W'(clamp_side(cmp_height_r));
        end
        DS_CHAN_BASE: begin
          mul_a = den_b_r[MUL_A_W-1:0];
          mul_b = MUL_B_W'(k);
        end
        DS_CHAN_CMP: begin
          mul_a = den_c_r[MUL_A_W-1:0];
          mul_b = MUL_B_W'(k);
        end
        DS_SCALE_BASE: begin
          mul_a = den_b_r[MUL_A_W-1:0];
          mul_b = MUL_B_W'(SAMPLE_FULL_SCALE);
        end
        DS_SCALE_CMP: begin
          mul_a = den_c_r[MUL_A_W-1:0];
          mul_b = MUL_B_W'(SAMPLE_FULL_SCALE);
        end
        default: ;
      endcase
    end else if (state_r == S_NUM) begin
      mul_a = side_r ? rd_cmp_sum : rd_base_sum;
      mul_b = MUL_B_W'(PERCENT);
    end
  end

  assign mul_p = mul_a * mul_b;

  // Shared divider: sum * 100 * 2^24 / denominator
  assign div_start    = (state_r == S_NUM);
  assign div_dividend = {mul_p[NUM_W-1:0], {FRAC_BITS{1'b0}}};
  assign div_divisor  = side_r ? den_c_r : den_b_r;

  mcd_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (div_dividend),
    .divisor  (div_divisor),
    .stat     (div_stat),
    .quotient (quotient)
  );

  // Saturate and grade the total
  assign diff_sat = (total_r > TOT_W'(DIFF_MAX)) ? DIFF_MAX : total_r[DIFF_W-1:0];

  always_comb begin
    priority if (diff_sat == '0) begin
      grade = VERDICT_IDENTICAL;
    end else if (diff_sat <= LIMIT_VERY_LIKELY) begin
      grade = VERDICT_VERY_LIKELY;
    end else if (diff_sat <= LIMIT_PROBABLY) begin
      grade = VERDICT_PROBABLY;
    end else if (diff_sat <= LIMIT_MAYBE) begin
      grade = VERDICT_MAYBE;
    end else begin
      grade = VERDICT_NOT_DUP;
    end
  end

  // Scoring sequencer
  always_comb begin
    state_nxt      = state_r;
    step_nxt       = step_r;
    ch_idx_nxt     = ch_idx_r;
    side_nxt       = side_r;
    den_b_nxt      = den_b_r;
    den_c_nxt      = den_c_r;
    vb_nxt         = vb_r;
    diff_nxt       = diff_r;
    total_nxt      = total_r;
    out_valid_nxt  = out_valid_r && !out_tready;
    verdict_nxt    = verdict_r;
    difference_nxt = difference_r;

    unique case (state_r)
      S_IDLE: begin
        if (in_tvalid && in_tlast) begin
          state_nxt = S_DEN;
          step_nxt  = DS_AREA_BASE;
          total_nxt = '0;
        end
      end
      S_DEN: begin
        if (step_r[0]) begin
          den_c_nxt = mul_p[DEN_W-1:0];
        end else begin
          den_b_nxt = mul_p[DEN_W-1:0];
        end
        step_nxt = step_r + 3'd1;
        if (step_r == DS_SCALE_CMP) begin
          state_nxt  = S_NUM;
          ch_idx_nxt = '0;
          side_nxt   = 1'b0;
        end
      end
      S_NUM: begin
        state_nxt = S_DIV;
      end
      S_DIV: begin
        if (div_stat.done) begin
          if (!side_r) begin
            vb_nxt    = quotient;
            side_nxt  = 1'b1;
            state_nxt = S_NUM;
          end else begin
            diff_nxt  = (quotient >= vb_r) ? (quotient - vb_r) : (vb_r - quotient);
            state_nxt = S_SUM;
          end
        end
      end
      S_SUM: begin
        total_nxt = total_r + TOT_W'(diff_r);
        side_nxt  = 1'b0;
        if (CHAN_W'(ch_idx_r + 3'd1) == k) begin
          state_nxt = S_GRADE;
        end else begin
          ch_idx_nxt = CHAN_W'(ch_idx_r + 3'd1);
          state_nxt  = S_NUM;
        end
      end
      S_GRADE: begin
        if (!out_valid_r || out_tready) begin
          out_valid_nxt  = 1'b1;
          verdict_nxt    = grade;
          difference_nxt = diff_sat;
          state_nxt      = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      step_r      <= '0;
      ch_idx_r    <= '0;
      side_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      step_r      <= step_nxt;
      ch_idx_r    <= ch_idx_nxt;
      side_r      <= side_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    den_b_r      <= den_b_nxt;
    den_c_r      <= den_c_nxt;
    vb_r         <= vb_nxt;
    diff_r       <= diff_nxt;
    total_r      <= total_nxt;
    verdict_r    <= verdict_nxt;
    difference_r <= difference_nxt;
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {{PAD_W{1'b0}}, difference_r, verdict_r};

endmodule

FILE: rtl/core/mcd_checker.sv
`timescale 1ns / 1ps
module mcd_checker (
  input logic                             clk,
  input logic                             rst_n,
  input logic                             in_tvalid,
  input logic                             in_tready,
  input logic                             in_tlast,
  input logic                             out_tvalid,
  input logic                             out_tready,
  input logic [mcd_pkg::OUT_TDATA_W-1:0]  out_tdata
);
  import mcd_pkg::*;

  // A stalled result holds its value
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
    else $error("result changed while stalled");

  // Verdict code stays within the defined grades
  a_verdict_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> out_tdata[VERDICT_W-1:0] <= VERDICT_NOT_DUP)
    else $error("verdict code out of range");

  // Identical exactly when the difference is zero
  a_identical_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> ((out_tdata[VERDICT_W-1:0] == VERDICT_IDENTICAL) ==
                    (out_tdata[VERDICT_W+DIFF_W-1:VERDICT_W] == '0)))
    else $error("verdict and difference disagree");

  // The last sample of a pair starts scoring and blocks input
  a_last_blocks: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready && in_tlast |=> !in_tready)
    else $error("input still ready after last sample");

  // Ordinary samples keep the stream open
  a_sample_open: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready && !in_tlast |=> in_tready)
    else $error("input blocked after ordinary sample");

endmodule

bind channel_mean_difference_classifier mcd_checker u_mcd_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tvalid  (in_tvalid),
  .in_tready  (in_tready),
  .in_tlast   (in_tlast),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata)
);
